// ===== sv/macs_pkg.sv =====
// Package for the moving average crossover block.
// Holds register codes, reset values, relation and signal codes and the item flag type.
// No dependencies.
`timescale 1ns / 1ps

package macs_pkg;

  // Default sizing handed to the top level
  localparam int MAX_WINDOW_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port
  localparam int CFG_W      = 9;
  localparam int CFG_AW     = 3;
  localparam int APB_DW     = 32;
  localparam logic [CFG_W-1:0] SHORT_LEN_RST = 9'd5;
  localparam logic [CFG_W-1:0] LONG_LEN_RST  = 9'd20;

  // Register index, taken from paddr bit 2
  localparam logic REG_SHORT_LEN = 1'b0;
  localparam logic REG_LONG_LEN  = 1'b1;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Relation of the short mean to the long mean
  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_ABOVE = 2'd1,
    REL_BELOW = 2'd2
  } rel_t;

  // Trade signal codes
  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_t;

  // Warm-up classification of one item
  typedef struct packed {
    logic eval;  // window full: compute a relation
    logic emit;  // one past full: a crossing may be reported
  } macs_flags_t;

endpackage

// ===== sv/macs_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
`timescale 1ns / 1ps

module macs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and read; a read of the address being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/macs_front.sv =====
// Front part of the crossover block: accepts prices, keeps the history ring and warm-up count.
// Fetches the samples leaving both windows. Depends on macs_pkg and macs_ram.
`timescale 1ns / 1ps

module macs_front
  import macs_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1),
  localparam int ENTRY_W     = 3 * SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    restart,
  input  logic [LEN_W-1:0]        s_len,
  input  logic [LEN_W-1:0]        l_len,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_price,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [ENTRY_W-1:0]      q_data,
  output macs_flags_t             q_flags
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int IDX_W  = LEN_W + 1;
  localparam int SEEN_W = $clog2(MAX_WINDOW + 2);

  logic                    accept;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [SEEN_W-1:0]       seen_r, seen_nxt;
  logic [SEEN_W-1:0]       seen_cap;
  logic [IDX_W-1:0]        back_s, back_l;
  logic [AW-1:0]           addr_s, addr_l;
  logic                    drop_s, drop_l;
  logic [SAMPLE_WIDTH-1:0] ram_s, ram_l;

  logic                    b_v_r, b_v_nxt;
  logic [SAMPLE_WIDTH-1:0] b_price_r;
  logic                    b_drop_s_r, b_drop_l_r;
  macs_flags_t             b_flags_r;

  // Hold off new transactions only while the fetch stage cannot drain
  assign in_stall = b_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = b_v_r && !q_full;

  // Ring positions of the samples leaving each window
  always_comb begin
    back_s = IDX_W'(wp_r) + IDX_W'(MAX_WINDOW) - IDX_W'(s_len);
    if (back_s >= IDX_W'(MAX_WINDOW)) begin
      back_s = back_s - IDX_W'(MAX_WINDOW);
    end
    back_l = IDX_W'(wp_r) + IDX_W'(MAX_WINDOW) - IDX_W'(l_len);
    if (back_l >= IDX_W'(MAX_WINDOW)) begin
      back_l = back_l - IDX_W'(MAX_WINDOW);
    end
    addr_s = AW'(back_s);
    addr_l = AW'(back_l);
  end

  // Warm-up count, drop decisions and write pointer advance
  assign seen_cap = SEEN_W'(l_len) + SEEN_W'(1);
  assign drop_s   = seen_r >= SEEN_W'(s_len);
  assign drop_l   = seen_r >= SEEN_W'(l_len);

  always_comb begin
    seen_nxt = seen_r;
    wp_nxt   = wp_r;
    if (accept) begin
      seen_nxt = (seen_r < seen_cap) ? seen_r + SEEN_W'(1) : seen_cap;
      wp_nxt   = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
    end
    if (restart) begin
      seen_nxt = '0;
    end
  end

  always_comb begin
    b_v_nxt = b_v_r;
    if (accept) begin
      b_v_nxt = 1'b1;
    end else if (q_push) begin
      b_v_nxt = 1'b0;
    end
  end

  // Two copies of the history ring, one per window edge
  macs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_WINDOW)) u_ram_short (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (in_price),
    .re    (accept),
    .raddr (addr_s),
    .rdata (ram_s)
  );

  macs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_WINDOW)) u_ram_long (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (in_price),
    .re    (accept),
    .raddr (addr_l),
    .rdata (ram_l)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      seen_r <= '0;
      b_v_r  <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      seen_r <= seen_nxt;
      b_v_r  <= b_v_nxt;
    end
  end

  // Fetch stage payload, captured with the RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      b_price_r      <= in_price;
      b_drop_s_r     <= drop_s;
      b_drop_l_r     <= drop_l;
      b_flags_r.eval <= seen_nxt >= SEEN_W'(l_len);
      b_flags_r.emit <= seen_nxt >= seen_cap;
    end
  end

  // Zero the leaving samples that are not yet part of a window
  assign q_data  = {b_price_r,
                    b_drop_s_r ? ram_s : SAMPLE_WIDTH'(0),
                    b_drop_l_r ? ram_l : SAMPLE_WIDTH'(0)};
  assign q_flags = b_flags_r;

  // An accepted transaction always lands in the fetch stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> b_v_r)
    else $error("accepted transaction did not reach fetch stage");

endmodule

// ===== sv/macs_queue.sv =====
// Short queue between the front and back parts of the crossover block.
// Depends on macs_pkg.
`timescale 1ns / 1ps

module macs_queue
  import macs_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  macs_flags_t      push_flags,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head_data,
  output macs_flags_t      head_flags
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] data_r  [QUEUE_DEPTH];
  macs_flags_t      flags_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full       = cnt_r == CW'(QUEUE_DEPTH);
  assign empty      = cnt_r == '0;
  assign head_data  = data_r[rd_r];
  assign head_flags = flags_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_r]  <= push_data;
      flags_r[wr_r] <= push_flags;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");

endmodule

// ===== sv/macs_back.sv =====
// Back part of the crossover block: running sums, cross-multiplied compare and signal.
// Depends on macs_pkg.
`timescale 1ns / 1ps

module macs_back
  import macs_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1),
  localparam int ENTRY_W     = 3 * SAMPLE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [LEN_W-1:0]   s_len,
  input  logic [LEN_W-1:0]   l_len,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_data,
  input  macs_flags_t        q_flags,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_signal
);

  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int PROD_W = SUM_W + LEN_W;

  logic                    adv;
  logic [SAMPLE_WIDTH-1:0] price, old_s, old_l;
  logic [SUM_W-1:0]        s_sum_r, s_sum_nxt, l_sum_r, l_sum_nxt;
  logic                    v1_r, v2_r, out_valid_r;
  macs_flags_t             flags1_r, flags2_r;
  logic [PROD_W-1:0]       prod_a_r, prod_b_r;
  rel_t                    rel, prev_rel_r, prev_rel_nxt;
  sig_t                    sig, out_signal_r;

  // Whole back pipeline moves unless the result register is stuck
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign price = q_data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
  assign old_s = q_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign old_l = q_data[SAMPLE_WIDTH-1:0];

  // Running sums: add the newest sample, drop the leaving one
  always_comb begin
    s_sum_nxt = s_sum_r;
    l_sum_nxt = l_sum_r;
    if (restart) begin
      s_sum_nxt = '0;
      l_sum_nxt = '0;
    end else if (q_pop) begin
      s_sum_nxt = SUM_W'({1'b0, s_sum_r} + (SUM_W+1)'(price) - (SUM_W+1)'(old_s));
      l_sum_nxt = SUM_W'({1'b0, l_sum_r} + (SUM_W+1)'(price) - (SUM_W+1)'(old_l));
    end
  end

  // Compare short*long_len against long*short_len
  always_comb begin
    if (prod_a_r > prod_b_r) begin
      rel = REL_ABOVE;
    end else if (prod_a_r < prod_b_r) begin
      rel = REL_BELOW;
    end else begin
      rel = REL_EQUAL;
    end
  end

  // Report a crossing only after warm-up
  always_comb begin
    sig = SIG_HOLD;
    if (v2_r && flags2_r.emit) begin
      if (prev_rel_r != REL_ABOVE && rel == REL_ABOVE) begin
        sig = SIG_BUY;
      end else if (prev_rel_r != REL_BELOW && rel == REL_BELOW) begin
        sig = SIG_SELL;
      end
    end
  end

  always_comb begin
    prev_rel_nxt = prev_rel_r;
    if (restart) begin
      prev_rel_nxt = REL_EQUAL;
    end else if (adv && v2_r && flags2_r.eval) begin
      prev_rel_nxt = rel;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_sum_r     <= '0;
      l_sum_r     <= '0;
      prev_rel_r  <= REL_EQUAL;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_sum_r    <= s_sum_nxt;
      l_sum_r    <= l_sum_nxt;
      prev_rel_r <= prev_rel_nxt;
      if (adv) begin
        v1_r        <= !q_empty;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  // Stage payload: flags, products, result
  always_ff @(posedge clk) begin
    if (adv) begin
      flags1_r     <= q_flags;
      flags2_r     <= flags1_r;
      prod_a_r     <= PROD_W'(s_sum_r) * PROD_W'(l_len);
      prod_b_r     <= PROD_W'(l_sum_r) * PROD_W'(s_len);
      out_signal_r <= sig;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_signal = out_signal_r;

  a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_pop && !restart) |=> ($stable(s_sum_r) && $stable(l_sum_r)))
    else $error("running sums moved without a transaction");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv) |=> v2_r)
    else $error("compare stage lost a transaction while stalled");

endmodule

// ===== sv/moving_average_crossover_signal.sv =====
// Moving average crossover: one hold/buy/sell result per price transaction.
// Throughput: one transaction per cycle unless in_stall or out_stall holds the flow;
// the fetch stage, the 2-entry queue and the sum/product/compare stages each move
// one item per cycle when not stalled.
// Reset: synchronous, active low; lengths return to 5 and 20, sums and warm-up clear.
// The history ring is not cleared; entries are read only after being written.
`timescale 1ns / 1ps

module moving_average_crossover_signal
  import macs_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_price,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_signal,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [APB_DW-1:0]       cfg_pwdata,
  output logic [APB_DW-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int ENTRY_W = 3 * SAMPLE_WIDTH;

  logic [CFG_W-1:0]   short_len_r, short_len_nxt, long_len_r, long_len_nxt;
  logic               cfg_wr, restart;
  logic [LEN_W-1:0]   l_eff, s_raw, s_eff;
  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_in_data, q_head_data;
  macs_flags_t        q_in_flags, q_head_flags;

  // Register writes; either length restarts warm-up
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    short_len_nxt = short_len_r;
    long_len_nxt  = long_len_r;
    restart       = 1'b0;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SHORT_LEN: begin
          short_len_nxt = cfg_pwdata[CFG_W-1:0];
          restart       = 1'b1;
        end
        REG_LONG_LEN: begin
          long_len_nxt = cfg_pwdata[CFG_W-1:0];
          restart      = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r <= SHORT_LEN_RST;
      long_len_r  <= LONG_LEN_RST;
    end else begin
      short_len_r <= short_len_nxt;
      long_len_r  <= long_len_nxt;
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_paddr[2])
      REG_SHORT_LEN: cfg_prdata = APB_DW'(short_len_r);
      REG_LONG_LEN:  cfg_prdata = APB_DW'(long_len_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Effective lengths: zero acts as one, cap at the ring size, short within long
  always_comb begin
    if (long_len_r == '0) begin
      l_eff = LEN_W'(1);
    end else if (int'(long_len_r) > MAX_WINDOW) begin
      l_eff = LEN_W'(MAX_WINDOW);
    end else begin
      l_eff = LEN_W'(long_len_r);
    end
    if (short_len_r == '0) begin
      s_raw = LEN_W'(1);
    end else if (int'(short_len_r) > MAX_WINDOW) begin
      s_raw = LEN_W'(MAX_WINDOW);
    end else begin
      s_raw = LEN_W'(short_len_r);
    end
    s_eff = (s_raw > l_eff) ? l_eff : s_raw;
  end

  macs_front #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .s_len    (s_eff),
    .l_len    (l_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_price (in_price),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in_data),
    .q_flags  (q_in_flags)
  );

  macs_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in_data),
    .push_flags (q_in_flags),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head_data  (q_head_data),
    .head_flags (q_head_flags)
  );

  macs_back #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .s_len      (s_eff),
    .l_len      (l_eff),
    .q_empty    (q_empty),
    .q_data     (q_head_data),
    .q_flags    (q_head_flags),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_signal (out_signal)
  );

endmodule

// ===== sim/tb_moving_average_crossover_signal.sv =====
// Testbench for moving_average_crossover_signal: drives price transactions, sets the
// window lengths over the APB port and checks every signal against a table or predictor.
// Depends on macs_pkg (sv/macs_pkg.sv) and the block's top level.
`timescale 1ns / 1ps

module tb_moving_average_crossover_signal;
  import macs_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW_DEF;
  localparam int DIR_ROWS   = 22;
  localparam int PHASES     = 8;

  // One row of the directed table; sig is used only where known is set
  typedef struct packed {
    logic [31:0] price;
    logic        known;
    sig_t        sig;
  } price_row_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [31:0]             in_price    = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [1:0]              out_signal;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]       cfg_paddr   = '0;
  logic [APB_DW-1:0]       cfg_pwdata  = '0;
  logic [APB_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // Predictor state
  logic [CFG_W-1:0] short_len_q = SHORT_LEN_RST;
  logic [CFG_W-1:0] long_len_q  = LONG_LEN_RST;
  logic [31:0]      price_hist [RING_DEPTH];
  logic [63:0]      short_sum = '0;
  logic [63:0]      long_sum  = '0;
  int unsigned      seen_cnt  = 0;
  int unsigned      wr_ptr    = 0;
  rel_t             last_rel  = REL_EQUAL;

  sig_t        pending_signals [$];
  int unsigned fail_count = 0;
  bit          idle_on    = 1'b1;
  logic [31:0] walk_level = '0;

  // Directed rows: reset lengths first, then short 1 / long 2
  price_row_t directed_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, SIG_HOLD},
    '{32'hFFFF_FFFF, 1'b1, SIG_HOLD},
    '{32'h0000_0001, 1'b1, SIG_HOLD},
    '{32'h8000_0000, 1'b1, SIG_HOLD},
    '{32'h0000_0000, 1'b1, SIG_HOLD},
    '{32'h0000_0000, 1'b1, SIG_HOLD},
    '{32'hFFFF_FFFF, 1'b1, SIG_BUY},
    '{32'hFFFF_FFFF, 1'b1, SIG_HOLD},
    '{32'h0000_0000, 1'b1, SIG_SELL},
    '{32'h0000_0000, 1'b1, SIG_HOLD},
    '{32'h0000_0000, 1'b1, SIG_HOLD},
    '{32'h0000_0001, 1'b1, SIG_BUY},
    '{32'h8000_0000, 1'b0, SIG_HOLD},
    '{32'h7FFF_FFFF, 1'b0, SIG_HOLD},
    '{32'hFFFF_FFFF, 1'b0, SIG_HOLD},
    '{32'h0000_0000, 1'b0, SIG_HOLD},
    '{32'h0000_0064, 1'b0, SIG_HOLD},
    '{32'h0000_00C8, 1'b0, SIG_HOLD},
    '{32'h0000_0096, 1'b0, SIG_HOLD},
    '{32'h0000_0096, 1'b0, SIG_HOLD},
    '{32'hDEAD_BEEF, 1'b0, SIG_HOLD},
    '{32'h0000_0005, 1'b0, SIG_HOLD}
  };

  moving_average_crossover_signal i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_price    (in_price),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_signal  (out_signal),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Map a length register onto the window it selects
  function automatic int unsigned window_len(input logic [CFG_W-1:0] len);
    if (len == 0) return 1;
    if (len > RING_DEPTH) return RING_DEPTH;
    return 32'(len);
  endfunction

  // Clear the sums and warm-up; the ring and its pointer are kept
  function automatic void restart_windows();
    short_sum = '0;
    long_sum  = '0;
    seen_cnt  = 0;
    last_rel  = REL_EQUAL;
  endfunction

  // Advance the windows by one price and return the trade signal it causes
  function automatic sig_t crossover_signal_of(input logic [31:0] price);
    int unsigned l_len, s_len;
    logic [31:0] old_s, old_l;
    logic [63:0] short_cross, long_cross;
    rel_t        now_rel;
    sig_t        result;
    l_len = window_len(long_len_q);
    s_len = window_len(short_len_q);
    if (s_len > l_len) s_len = l_len;
    old_s = '0;
    old_l = '0;
    if (seen_cnt >= s_len) old_s = price_hist[(wr_ptr + RING_DEPTH - s_len) % RING_DEPTH];
    if (seen_cnt >= l_len) old_l = price_hist[(wr_ptr + RING_DEPTH - l_len) % RING_DEPTH];
    price_hist[wr_ptr] = price;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    short_sum = short_sum + price - old_s;
    long_sum  = long_sum + price - old_l;
    if (seen_cnt < l_len + 1) seen_cnt++;
    result = SIG_HOLD;
    if (seen_cnt >= l_len) begin
      // Compare means by cross-multiplying sums and lengths
      short_cross = short_sum * l_len;
      long_cross  = long_sum * s_len;
      if (short_cross > long_cross) now_rel = REL_ABOVE;
      else if (short_cross < long_cross) now_rel = REL_BELOW;
      else now_rel = REL_EQUAL;
      if (seen_cnt == l_len + 1) begin
        if (last_rel != REL_ABOVE && now_rel == REL_ABOVE) result = SIG_BUY;
        else if (last_rel != REL_BELOW && now_rel == REL_BELOW) result = SIG_SELL;
      end
      last_rel = now_rel;
    end
    return result;
  endfunction

  // Mostly a saturating random walk, now and then a wild or extreme price
  function automatic logic [31:0] next_price();
    logic [31:0] step;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom;
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
    step = $urandom_range(0, 1 << $urandom_range(0, 16));
    if ($urandom_range(0, 1) != 0) begin
      walk_level = (walk_level + step < walk_level) ? 32'hFFFF_FFFF : walk_level + step;
    end else begin
      walk_level = (walk_level < step) ? 32'h0000_0000 : walk_level - step;
    end
    return walk_level;
  endfunction

  // Write one length register, then read it back
  task automatic write_len(input logic idx, input logic [CFG_W-1:0] len);
    logic [31:0] noise;
    noise = $urandom;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {noise[31:CFG_W], len};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_SHORT_LEN) short_len_q = len;
    else long_len_q = len;
    restart_windows();
    // Read back through a fresh setup phase
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[CFG_W-1:0] !== len) begin
      $error("prdata: expected %0d, got %0d", len, cfg_prdata[CFG_W-1:0]);
      fail_count++;
    end
    // Return the bus to idle
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Hold one price until accepted, queue its signal, then maybe idle
  task automatic send_price(input logic [31:0] price, input logic known, input sig_t typed);
    sig_t predicted;
    in_valid <= 1'b1;
    in_price <= price;
    do @(posedge clk); while (in_stall);
    predicted = crossover_signal_of(price);
    if (known) pending_signals.push_back(typed);
    else pending_signals.push_back(predicted);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every queued signal to drain
  task automatic drain_signals();
    in_valid <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
  endtask

  // Receiver stall in random bursts
  always @(posedge clk) begin : rx_stall
    int unsigned left_n;
    int unsigned stall_left;
    if (stall_left != 0) left_n = stall_left - 1;
    else if (idle_on && $urandom_range(0, 9) == 0) left_n = $urandom_range(1, 7);
    else left_n = 0;
    stall_left = left_n;
    out_stall <= (left_n != 0);
  end

  // Check each accepted result against the oldest queued signal
  always @(posedge clk) begin : signal_check
    sig_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_signals.size() == 0) begin
        $error("signal: expected none, got %0d", out_signal);
        fail_count++;
      end else begin
        want = pending_signals.pop_front();
        if (out_signal !== want) begin
          $error("signal: expected %0d, got %0d", want, out_signal);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] s_len, l_len;
    int unsigned      n_items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; switch to short 1 / long 2 after the warm-up rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 4) begin
        drain_signals();
        write_len(REG_SHORT_LEN, 9'd1);
        write_len(REG_LONG_LEN, 9'd2);
      end
      send_price(directed_rows[i].price, directed_rows[i].known, directed_rows[i].sig);
    end

    // Random phases: zero lengths, clamped short, zero short, oversize long, random lengths
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          s_len = 9'd0;   l_len = 9'd0;   n_items = 30;
        end
        1: begin
          s_len = 9'd256; l_len = 9'd3;   n_items = 30;
        end
        2: begin
          s_len = 9'd0;   l_len = 9'd4;   n_items = 60;
        end
        3: begin
          s_len = 9'd200; l_len = 9'd511; n_items = 300;
        end
        default: begin
          s_len = CFG_W'($urandom_range(0, 16));
          l_len = CFG_W'($urandom_range(0, 40));
          n_items = 80;
        end
      endcase
      drain_signals();
      write_len(REG_SHORT_LEN, s_len);
      write_len(REG_LONG_LEN, l_len);
      walk_level = $urandom;
      idle_on = (ph != PHASES - 1);
      for (int k = 0; k < n_items; k++) begin
        send_price(next_price(), 1'b0, SIG_HOLD);
      end
    end

    // Let the pipeline drain, then report
    drain_signals();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
